// ===== rtl/lpm_pkg.sv =====
// types shared by the longest prefix match lookup unit and its compare unit
// command and result payloads, stored route entry layout, running rank
// no dependencies
package lpm_pkg;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } lpm_op_e;

  // one command transfer
  typedef struct packed {
    lpm_op_e     command;
    logic [9:0]  entry_index;
    logic [31:0] entry_prefix;
    logic [31:0] entry_mask;
    logic [31:0] entry_next_hop;
    logic [7:0]  entry_port;
    logic [31:0] lookup_address;
  } lpm_cmd_t;

  // one result transfer
  typedef struct packed {
    logic        route_found;
    logic [31:0] hop_address;
    logic [7:0]  out_port;
    logic [5:0]  match_length;
    logic [9:0]  match_slot;
  } lpm_res_t;

  // route entry as kept in the table, mask bit count computed on write
  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [7:0]  port;
    logic [5:0]  len;
  } lpm_entry_t;

  // best match so far in a scan
  typedef struct packed {
    logic       found;
    logic [5:0] len;
  } lpm_rank_t;

endpackage

// ===== rtl/longest_prefix_match_lookup_unit.sv =====
// ipv4 longest prefix match route lookup, top level
// depends on lpm_pkg, lpm_ram (route table) and lpm_match (compare unit)
//
// usage
// - commands come in on cmd_i and are taken at a clock edge with start high
//   and busy low; every command gives exactly one result on res_o, marked by
//   a one-cycle done_o strobe; the receiver has no way to stall a result
// - a write command (CMD_WRITE) loads prefix, mask, next hop and port into
//   slot entry_index; slots at or above TABLE_DEPTH are left untouched; the
//   result is all zero and shows in the next cycle, busy stays low
// - a lookup command (CMD_LOOKUP) scans slots 0 .. N-1 with
//   N = min(entries_in_use, TABLE_DEPTH), one slot per cycle through the one
//   table read port and the shared compare unit; busy stays high until the
//   strobe, set from ST_DRAIN; with N zero the zero result comes next cycle
// - the longest mask wins, on a tie the lowest slot; no match gives all zero
// - entries_in_use is written through cfg_we_i / cfg_wdata_i; the user must
//   do so only while idle, the block itself does not enforce it
// - reset clears the sequencer and sets entries_in_use to zero; the table
//   itself is not cleared and a slot must be written before it is searched
module longest_prefix_match_lookup_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lpm_pkg::lpm_cmd_t cmd_i,
  output logic              done_o,
  output lpm_pkg::lpm_res_t res_o,
  input  logic              cfg_we_i,
  input  logic [10:0]       cfg_wdata_i
);
  import lpm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EW = $bits(lpm_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } lpm_state_e;

  typedef struct packed {
    logic        found;
    logic [5:0]  len;
    logic [9:0]  slot;
    logic [31:0] hop;
    logic [7:0]  port;
  } lpm_best_t;

  // mask bit count as a five level adder tree
  function automatic logic [5:0] popcount32(logic [31:0] v);
    logic [1:0] s1 [16];
    logic [2:0] s2 [8];
    logic [3:0] s3 [4];
    logic [4:0] s4 [2];
    for (int i = 0; i < 16; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 8; i++)  s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 4; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 2; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    return {1'b0, s4[0]} + {1'b0, s4[1]};
  endfunction

  lpm_state_e  state_q, state_d;
  logic [10:0] cfg_q;
  logic [10:0] limit_q, limit_d;
  logic [10:0] cnt_q, cnt_d;
  logic [31:0] addr_q, addr_d;
  logic        rd_vld_q, rd_vld_d;
  logic [9:0]  rd_slot_q, rd_slot_d;
  lpm_best_t   best_q, best_d;
  logic        done_q, done_d;
  lpm_res_t    res_q, res_d;

  logic        accept;
  logic [10:0] lim;
  logic        in_range;
  logic        ram_we;
  logic [AW+9:0]  widx_ext;
  logic [AW+10:0] ridx_ext;
  lpm_entry_t  wr_entry;
  lpm_entry_t  rd_entry;
  logic [EW-1:0] rd_bits;
  lpm_rank_t   rank;
  logic        take;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // number of slots to scan, clamped to the table
  assign lim = (32'(cfg_q) > 32'(TABLE_DEPTH)) ? 11'(TABLE_DEPTH) : cfg_q;

  assign in_range = (32'(cmd_i.entry_index) < 32'(TABLE_DEPTH));
  assign widx_ext = {{AW{1'b0}}, cmd_i.entry_index};
  assign ridx_ext = {{AW{1'b0}}, cnt_q};

  assign wr_entry = '{
    prefix: cmd_i.entry_prefix,
    mask:   cmd_i.entry_mask,
    hop:    cmd_i.entry_next_hop,
    port:   cmd_i.entry_port,
    len:    popcount32(cmd_i.entry_mask)
  };

  lpm_ram #(
    .Width (EW),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_ext[AW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (ridx_ext[AW-1:0]),
    .rdata_o (rd_bits)
  );

  assign rd_entry = lpm_entry_t'(rd_bits);
  assign rank     = '{found: best_q.found, len: best_q.len};

  lpm_match u_match (
    .entry_i (rd_entry),
    .addr_i  (addr_q),
    .rank_i  (rank),
    .take_o  (take)
  );

  always_comb begin
    state_d   = state_q;
    limit_d   = limit_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    rd_vld_d  = 1'b0;
    rd_slot_d = rd_slot_q;
    best_d    = best_q;
    done_d    = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;

    // fold in the entry read last cycle
    if (rd_vld_q && take) begin
      best_d = '{found: 1'b1, len: rd_entry.len, slot: rd_slot_q,
                 hop: rd_entry.hop, port: rd_entry.port};
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i.command == CMD_WRITE) begin
            ram_we = in_range;
            done_d = 1'b1;
            res_d  = '0;
          end else begin
            limit_d = lim;
            addr_d  = cmd_i.lookup_address;
            cnt_d   = '0;
            best_d  = '0;
            if (lim == 11'd0) begin
              done_d = 1'b1;
              res_d  = '0;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        // one table read per cycle, compared on the next
        rd_vld_d  = 1'b1;
        rd_slot_d = cnt_q[9:0];
        cnt_d     = cnt_q + 11'd1;
        if (cnt_q == limit_q - 11'd1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last entry folds in now, best is final
        done_d  = 1'b1;
        res_d   = '{route_found: best_d.found, hop_address: best_d.hop,
                    out_port: best_d.port, match_length: best_d.len,
                    match_slot: best_d.slot};
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cfg_q    <= '0;
      limit_q  <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      best_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      limit_q  <= limit_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      best_q   <= best_d;
      done_q   <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    rd_slot_q <= rd_slot_d;
    res_q     <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/lpm_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module lpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lpm_match.sv =====
// shared compare unit: tests one table entry against the address and
// decides whether it beats the best match so far; depends on lpm_pkg
module lpm_match (
  input  lpm_pkg::lpm_entry_t entry_i,
  input  logic [31:0]         addr_i,
  input  lpm_pkg::lpm_rank_t  rank_i,
  output logic                take_o
);
  import lpm_pkg::*;

  logic hit;

  // prefix and address agree on every mask bit
  assign hit    = (((entry_i.prefix ^ addr_i) & entry_i.mask) == 32'd0);
  // strictly longer wins, so on a tie the earlier slot stays
  assign take_o = hit && (!rank_i.found || (entry_i.len > rank_i.len));

endmodule
